>>> sv/mosaic_block_average_assert.svh
// Assertion macros shared by the mosaic block averager RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MOSAIC_BLOCK_AVERAGE_ASSERT_SVH
`define MOSAIC_BLOCK_AVERAGE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define MBA_ASSERT_NOW(label, clk, rst, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error("mosaic block average check failed");

// Next-cycle implication, off during reset.
`define MBA_ASSERT_NEXT(label, clk, rst, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error("mosaic block average check failed");

`endif

>>> sv/mba_pkg.sv
// Shared types and constants for the mosaic block averager.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mba_pkg;

  localparam int MAX_LINE_PIXELS = 1024;
  localparam int MAX_BLOCK_SIDE  = 64;
  localparam int MAX_LINES       = 4096;

  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 20;
  localparam int COL_W   = 10;
  localparam int LINE_W  = 12;
  localparam int INBLK_W = 6;
  localparam int IW_W    = 11;
  localparam int IH_W    = 13;
  localparam int BS_W    = 7;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int MEM_DEPTH = MAX_LINE_PIXELS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 13;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_BLOCK_WIDTH,
    REG_BLOCK_HEIGHT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_MEM,
    S_UPD,
    S_GEO1,
    S_GEO2,
    S_GEO3,
    S_GEO4,
    S_PROD,
    S_TOT,
    S_DIVC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic              frame_start;
  } pix_t;

  typedef struct packed {
    logic [COL_W-1:0]  block_col;
    logic [LINE_W-1:0] block_row;
    logic [CHAN_W-1:0] avg_red;
    logic [CHAN_W-1:0] avg_green;
    logic [CHAN_W-1:0] avg_blue;
    logic              frame_last;
  } blk_t;

  // One block column entry: running sums and top-left color per channel.
  typedef struct packed {
    logic [2:0][SUM_W-1:0]  sums;
    logic [2:0][CHAN_W-1:0] corner;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

`default_nettype wire

>>> sv/mosaic_block_average.sv
// Channel   | Handshake            | Payload
// pix       | pix_valid/pix_ready  | pix_t: in_red, in_green, in_blue, frame_start
// blk       | blk_valid/blk_ready  | blk_t: block_col, block_row, avg_*, frame_last
// cfg       | cfg_valid/cfg_ready  | cfg_index, cfg_data (ready while idle, no pixel offered)
//
// One pixel at a time: a new pixel is taken only once the previous one is through.
// Most of the work per pixel is in the shared one-bit-per-cycle divider:
// two 22-step divisions for the block position, three more for the averages of a completed block.
// Reset is synchronous; no clearing pass (entries are written at each corner).
// A finished result waits in the output register while the next pixel runs.
// Top level; uses mba_pkg, mba_div, mba_store and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "mosaic_block_average_assert.svh"

module mosaic_block_average import mba_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pix_valid,
  output logic                       pix_ready,
  input  wire pix_t                  pix,
  output logic                       blk_valid,
  input  wire logic                  blk_ready,
  output blk_t                       blk,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [IW_W-1:0] W_MAX  = IW_W'(MAX_LINE_PIXELS);
  localparam logic [IH_W-1:0] H_MAX  = IH_W'(MAX_LINES);
  localparam logic [BS_W-1:0] BS_MAX = BS_W'(MAX_BLOCK_SIDE);

  state_t state, state_next;

  logic [IW_W-1:0] image_width;
  logic [IH_W-1:0] image_height;
  logic [BS_W-1:0] block_width;
  logic [BS_W-1:0] block_height;

  logic [IW_W-1:0] w;
  logic [IH_W-1:0] h;
  logic [BS_W-1:0] bw;
  logic [BS_W-1:0] bh;

  logic [COL_W-1:0]   pixel_column;
  logic [LINE_W-1:0]  pixel_line;
  logic [INBLK_W-1:0] column_within_block;
  logic [INBLK_W-1:0] line_within_block;

  pix_t              pix_q;
  logic [CHAN_W-1:0] px [3];
  logic              pix_acc;
  logic              pos_bad;
  logic              last_col, last_line, cwb_wrap, lwb_wrap;
  logic              corner_pos, emit;

  logic [COL_W-1:0]  bx;
  logic [LINE_W-1:0] by;

  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  mem_rd_t rd;
  mem_wr_t wr;
  entry_t  rdata;

  logic [SUM_W-1:0]     sum_new [3];
  logic [CHAN_W-1:0]    corner_new [3];
  logic [SUM_W-1:0]     sum_q [3];
  logic [CHAN_W-1:0]    corner_q [3];
  logic                 frame_last_q;
  logic [16:0]          x0_q;
  logic [18:0]          y0_q;
  logic [IH_W-1:0]      area_q;
  logic [16:0]          cols_raw;
  logic [18:0]          rows_raw;
  logic [BS_W-1:0]      cols_q, rows_q;
  logic                 in_img_q;
  logic [IH_W-1:0]      inside_q, outside_q;
  logic [20:0]          prod_q [3];
  logic [DIV_NUM_W-1:0] total_q [3];
  logic [1:0]           chan;
  logic [CHAN_W-1:0]    avg_q [3];
  logic                 blk_load;

  // Configuration registers: take a transfer only between pixels
  assign cfg_ready = !rst && (state == S_IDLE) && !pix_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IW_W'(640);
      image_height <= IH_W'(480);
      block_width  <= BS_W'(8);
      block_height <= BS_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IW_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IH_W-1:0];
        REG_BLOCK_WIDTH:  block_width  <= cfg_data[BS_W-1:0];
        REG_BLOCK_HEIGHT: block_height <= cfg_data[BS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry: zero acts as one, oversize saturates
  always_comb begin
    w  = (image_width == '0) ? IW_W'(1) : ((image_width > W_MAX) ? W_MAX : image_width);
    h  = (image_height == '0) ? IH_W'(1) :
         ((image_height > H_MAX) ? H_MAX : image_height);
    bw = (block_width == '0) ? BS_W'(1) : ((block_width > BS_MAX) ? BS_MAX : block_width);
    bh = (block_height == '0) ? BS_W'(1) :
         ((block_height > BS_MAX) ? BS_MAX : block_height);
  end

  // Position status
  always_comb begin
    pix_acc    = pix_valid && pix_ready;
    pos_bad    = pix.frame_start || (IW_W'(pixel_column) >= w) || (IH_W'(pixel_line) >= h) ||
                 (BS_W'(column_within_block) >= bw) || (BS_W'(line_within_block) >= bh);
    last_col   = IW_W'(pixel_column) == (w - IW_W'(1));
    last_line  = IH_W'(pixel_line) == (h - IH_W'(1));
    cwb_wrap   = BS_W'(column_within_block) == (bw - BS_W'(1));
    lwb_wrap   = BS_W'(line_within_block) == (bh - BS_W'(1));
    corner_pos = (column_within_block == '0) && (line_within_block == '0);
    emit       = (cwb_wrap || last_col) && (lwb_wrap || last_line);
  end

  // Position counters: restart on frame start or an out-of-range position, advance after the update
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column        <= '0;
      pixel_line          <= '0;
      column_within_block <= '0;
      line_within_block   <= '0;
    end else if (pix_acc && pos_bad) begin
      pixel_column        <= '0;
      pixel_line          <= '0;
      column_within_block <= '0;
      line_within_block   <= '0;
    end else if (state == S_UPD) begin
      if (last_col) begin
        pixel_column        <= '0;
        column_within_block <= '0;
        if (last_line) begin
          pixel_line        <= '0;
          line_within_block <= '0;
        end else begin
          pixel_line        <= pixel_line + LINE_W'(1);
          line_within_block <= lwb_wrap ? '0 : line_within_block + INBLK_W'(1);
        end
      end else begin
        pixel_column        <= pixel_column + COL_W'(1);
        column_within_block <= cwb_wrap ? '0 : column_within_block + INBLK_W'(1);
      end
    end
  end

  // Hold the accepted pixel
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pix_q <= pix;
    end
  end

  assign px[0] = pix_q.in_red;
  assign px[1] = pix_q.in_green;
  assign px[2] = pix_q.in_blue;

  // Shared divider
  mba_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Block column store
  mba_store u_store (
    .clk   (clk),
    .rd    (rd),
    .wr    (wr),
    .rdata (rdata)
  );

  // Read-modify-write values for the current entry
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_new[c]    = corner_pos ? SUM_W'(px[c]) : rdata.sums[c] + SUM_W'(px[c]);
      corner_new[c] = corner_pos ? px[c] : rdata.corner[c];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (pix_acc) state_next = S_DIVX;
      S_DIVX: if (div_done) state_next = S_DIVY;
      S_DIVY: if (div_done) state_next = S_MEM;
      S_MEM:  state_next = S_UPD;
      S_UPD:  state_next = emit ? S_GEO1 : S_IDLE;
      S_GEO1: state_next = S_GEO2;
      S_GEO2: state_next = S_GEO3;
      S_GEO3: state_next = S_GEO4;
      S_GEO4: state_next = S_PROD;
      S_PROD: state_next = S_TOT;
      S_TOT:  state_next = S_DIVC;
      S_DIVC: if (div_done && chan == 2'd2) state_next = S_DONE;
      S_DONE: if (!blk_valid || blk_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    pix_ready = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DIV_DEN_W'(1);
    rd        = '0;
    wr        = '0;
    blk_load  = 1'b0;
    case (state)
      S_IDLE: pix_ready = !rst;
      S_DIVX: begin
        div_start = !div_busy;
        div_num   = DIV_NUM_W'(pixel_column);
        div_den   = DIV_DEN_W'(bw);
      end
      S_DIVY: begin
        div_start = !div_busy;
        div_num   = DIV_NUM_W'(pixel_line);
        div_den   = DIV_DEN_W'(bh);
      end
      S_MEM: begin
        rd.en   = 1'b1;
        rd.addr = bx;
      end
      S_UPD: begin
        wr.en   = 1'b1;
        wr.addr = bx;
        for (int c = 0; c < 3; c++) begin
          wr.data.sums[c]   = sum_new[c];
          wr.data.corner[c] = corner_new[c];
        end
      end
      S_DIVC: begin
        div_start = !div_busy;
        div_num   = total_q[chan];
        div_den   = area_q;
      end
      S_DONE: blk_load = !blk_valid || blk_ready;
      default: ;
    endcase
  end

  // Block position from the divider
  always_ff @(posedge clk) begin
    if (state == S_DIVX && div_done) begin
      bx <= div_quot[COL_W-1:0];
    end
    if (state == S_DIVY && div_done) begin
      by <= div_quot[LINE_W-1:0];
    end
  end

  // Average datapath: geometry, padding term, totals
  always_comb begin
    cols_raw = 17'(w) - x0_q;
    rows_raw = 19'(h) - y0_q;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_UPD: begin
        for (int c = 0; c < 3; c++) begin
          sum_q[c]    <= sum_new[c];
          corner_q[c] <= corner_new[c];
        end
        frame_last_q <= last_col && last_line;
      end
      S_GEO1: begin
        x0_q   <= 17'(bx * bw);
        y0_q   <= 19'(by * bh);
        area_q <= IH_W'(bw * bh);
      end
      S_GEO2: begin
        in_img_q <= (x0_q < 17'(w)) && (y0_q < 19'(h));
        cols_q   <= (cols_raw < 17'(bw)) ? cols_raw[BS_W-1:0] : bw;
        rows_q   <= (rows_raw < 19'(bh)) ? rows_raw[BS_W-1:0] : bh;
      end
      S_GEO3: inside_q <= in_img_q ? IH_W'(cols_q * rows_q) : '0;
      S_GEO4: outside_q <= (inside_q < area_q) ? area_q - inside_q : '0;
      S_PROD: begin
        for (int c = 0; c < 3; c++) begin
          prod_q[c] <= 21'(outside_q * corner_q[c]);
        end
      end
      S_TOT: begin
        for (int c = 0; c < 3; c++) begin
          total_q[c] <= DIV_NUM_W'(sum_q[c]) + DIV_NUM_W'(prod_q[c]);
        end
      end
      S_DIVC: begin
        if (div_done) begin
          avg_q[chan] <= (div_quot > DIV_NUM_W'(CHAN_MAX)) ? CHAN_MAX : div_quot[CHAN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Channel counter for the average divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      chan <= '0;
    end else if (state == S_TOT) begin
      chan <= '0;
    end else if (state == S_DIVC && div_done) begin
      chan <= chan + 2'd1;
    end
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (blk_load) begin
      blk_valid <= 1'b1;
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_load) begin
      blk.block_col  <= bx;
      blk.block_row  <= by;
      blk.avg_red    <= avg_q[0];
      blk.avg_green  <= avg_q[1];
      blk.avg_blue   <= avg_q[2];
      blk.frame_last <= frame_last_q;
    end
  end

  // Checks
  `MBA_ASSERT_NOW(a_div_done_in_div_state, clk, rst, div_done,
                  state == S_DIVX || state == S_DIVY || state == S_DIVC)
  `MBA_ASSERT_NEXT(a_counters_in_block, clk, rst, state == S_UPD,
                   BS_W'(column_within_block) < bw && BS_W'(line_within_block) < bh)
  `MBA_ASSERT_NEXT(a_result_loaded, clk, rst, state == S_DONE && !blk_valid, blk_valid)

endmodule

`default_nettype wire

>>> sv/mba_store.sv
// Block column store: sums and corner color per block column.
// Synchronous RAM, one write and one registered read per cycle; uses mba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mba_store import mba_pkg::*; (
  input  wire logic    clk,
  input  wire mem_rd_t rd,
  input  wire mem_wr_t wr,
  output entry_t       rdata
);

  entry_t mem [MEM_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/mba_div.sv
// Restoring divider, one quotient bit per cycle.
// Shared by block index and average computation; uses mba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mba_div import mba_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] quo_next;
  logic             last;

  // One trial subtraction per cycle
  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    ge       = trial >= {1'b0, den_q};
    diff     = trial - {1'b0, den_q};
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_next = {quo[NUM_W-2:0], ge};
    last     = cnt == CNT_W'(NUM_W - 1);
  end

  assign done = busy && last;
  assign quot = quo_next;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire
